// ----- rtl/core/ptts_pkg.sv -----
package ptts_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int CMD_W     = 3;
    localparam int IDX_W     = 8;
    localparam int TIME_W    = 32;
    localparam int STAT_W    = 2;
    localparam int MASK_W    = 8;

    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUSPEND = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESUME  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_USED  = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    // write request into the period / countdown store
    typedef struct packed {
        logic              we_cd;
        logic              we_per;
        logic [SLOT_W-1:0] addr;
        logic [TIME_W-1:0] cd;
        logic [TIME_W-1:0] per;
    } t_wr_req;

endpackage

// ----- rtl/core/periodic_task_tick_scheduler.sv -----
// Periodic task tick scheduler. Each command word on the input stream (tuser = command:
// tick, create, suspend, resume, delete) yields exactly one result word carrying a status
// and, for a tick, the mask of slots that fired. Create, suspend, resume and delete finish
// in the cycle they are accepted, and their result is registered in the output register. A tick
// walks the slot table through one shared zero-check/decrement unit, one slot per cycle
// behind a registered read of the period/countdown store, and then offers its result; the
// input is not ready meanwhile, nor while a finished result waits and a new one would
// need the output register.
module periodic_task_tick_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,   // task_index[7:0], period[39:8], first_delay[71:40]
    input  logic [2:0]  i_s_axis_tuser,   // command[2:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // status[1:0], fired_mask[9:2], zero pad[15:10]
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_OUT
    } t_state;

    t_state                          r_state,   n_state;
    logic [ptts_pkg::NUM_SLOTS-1:0]  r_used,    n_used;
    logic [ptts_pkg::NUM_SLOTS-1:0]  r_running, n_running;
    logic [ptts_pkg::CNT_W-1:0]      r_issue,   n_issue;
    logic                            r_proc_vld, n_proc_vld;
    logic [ptts_pkg::SLOT_W-1:0]     r_proc_idx, n_proc_idx;
    logic [ptts_pkg::MASK_W-1:0]     r_mask,    n_mask;
    logic                            r_out_vld, n_out_vld;
    logic [15:0]                     r_out_data, n_out_data;

    ptts_pkg::t_wr_req               wr;
    logic [ptts_pkg::SLOT_W-1:0]     rd_addr;
    logic [ptts_pkg::TIME_W-1:0]     rd_cd;
    logic [ptts_pkg::TIME_W-1:0]     rd_per;

    logic [ptts_pkg::CMD_W-1:0]      cmd;
    logic [ptts_pkg::IDX_W-1:0]      idx;
    logic [ptts_pkg::SLOT_W-1:0]     slot;
    logic                            accept;
    logic                            out_free;
    logic                            issuing;
    logic                            proc_live;
    logic [ptts_pkg::STAT_W-1:0]     status;

    assign cmd      = i_s_axis_tuser;
    assign idx      = i_s_axis_tdata[7:0];
    assign slot     = idx[ptts_pkg::SLOT_W-1:0];
    assign out_free = !r_out_vld || i_m_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE) && out_free;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    assign issuing   = (r_state == S_TICK) && (r_issue < ptts_pkg::CNT_W'(ptts_pkg::NUM_SLOTS));
    assign rd_addr   = r_issue[ptts_pkg::SLOT_W-1:0];
    assign proc_live = r_proc_vld && r_used[r_proc_idx] && r_running[r_proc_idx];

    ptts_slot_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_cd   (rd_cd),
        .o_rd_per  (rd_per)
    );

    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_running  = r_running;
        n_issue    = r_issue;
        n_proc_vld = 1'b0;
        n_proc_idx = rd_addr;
        n_mask     = r_mask;
        n_out_vld  = r_out_vld && !i_m_axis_tready;
        n_out_data = r_out_data;
        status     = ptts_pkg::ST_OK;

        wr.we_cd  = 1'b0;
        wr.we_per = 1'b0;
        wr.addr   = slot;
        wr.cd     = i_s_axis_tdata[71:40];
        wr.per    = i_s_axis_tdata[39:8];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (cmd == ptts_pkg::CMD_TICK) begin
                        n_state = S_TICK;
                        n_issue = '0;
                        n_mask  = '0;
                    end else if (cmd == ptts_pkg::CMD_CREATE || cmd == ptts_pkg::CMD_SUSPEND
                                 || cmd == ptts_pkg::CMD_RESUME
                                 || cmd == ptts_pkg::CMD_DELETE) begin
                        if (idx >= ptts_pkg::IDX_W'(ptts_pkg::NUM_SLOTS)) begin
                            status = ptts_pkg::ST_RANGE;
                        end else if (cmd == ptts_pkg::CMD_CREATE) begin
                            if (r_used[slot]) begin
                                status = ptts_pkg::ST_USED;
                            end else begin
                                n_used[slot]    = 1'b1;
                                n_running[slot] = 1'b1;
                                wr.we_cd        = 1'b1;
                                wr.we_per       = 1'b1;
                            end
                        end else if (!r_used[slot]) begin
                            status = ptts_pkg::ST_EMPTY;
                        end else if (cmd == ptts_pkg::CMD_SUSPEND) begin
                            n_running[slot] = 1'b0;
                        end else if (cmd == ptts_pkg::CMD_RESUME) begin
                            n_running[slot] = 1'b1;
                        end else begin
                            n_used[slot]    = 1'b0;
                            n_running[slot] = 1'b0;
                        end
                    end
                    if (cmd != ptts_pkg::CMD_TICK) begin
                        n_out_vld  = 1'b1;
                        n_out_data = {6'd0, {ptts_pkg::MASK_W{1'b0}}, status};
                    end
                end
            end
            S_TICK: begin
                // read of slot k+1 overlaps the update of slot k
                if (issuing) begin
                    n_issue    = r_issue + 1'b1;
                    n_proc_vld = 1'b1;
                end
                if (proc_live) begin
                    wr.we_cd = 1'b1;
                    wr.addr  = r_proc_idx;
                    if (rd_cd == '0) begin
                        wr.cd = rd_per;
                        for (int b = 0; b < ptts_pkg::MASK_W; b++) begin
                            if (8'(r_proc_idx) == 8'(b)) begin
                                n_mask[b] = 1'b1;
                            end
                        end
                    end else begin
                        wr.cd = rd_cd - 1'b1;
                    end
                end
                if (!issuing && !r_proc_vld) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {6'd0, r_mask, ptts_pkg::ST_OK};
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_used     <= '0;
            r_running  <= '0;
            r_issue    <= '0;
            r_proc_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_running  <= n_running;
            r_issue    <= n_issue;
            r_proc_vld <= n_proc_vld;
            r_out_vld  <= n_out_vld;
        end
        r_proc_idx <= n_proc_idx;
        r_mask     <= n_mask;
        r_out_data <= n_out_data;
    end

endmodule

// ----- rtl/core/ptts_slot_store.sv -----
module ptts_slot_store (
    input  logic                            i_clk,
    input  ptts_pkg::t_wr_req               i_wr,
    input  logic [ptts_pkg::SLOT_W-1:0]     i_rd_addr,
    output logic [ptts_pkg::TIME_W-1:0]     o_rd_cd,
    output logic [ptts_pkg::TIME_W-1:0]     o_rd_per
);

    logic [ptts_pkg::TIME_W-1:0] mem_cd  [ptts_pkg::NUM_SLOTS];
    logic [ptts_pkg::TIME_W-1:0] mem_per [ptts_pkg::NUM_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_wr.we_cd) begin
            mem_cd[i_wr.addr] <= i_wr.cd;
        end
        if (i_wr.we_per) begin
            mem_per[i_wr.addr] <= i_wr.per;
        end
        o_rd_cd  <= mem_cd[i_rd_addr];
        o_rd_per <= mem_per[i_rd_addr];
    end

endmodule

// ----- tb/tick_sched_checker.sv -----
`timescale 1ns / 100ps

module tick_sched_checker
    import ptts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,   // task_index[7:0], period[39:8], first_delay[71:40]
    input  logic [2:0]  i_s_axis_tuser,   // command[2:0]
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [15:0] i_m_axis_tdata,   // status[1:0], fired_mask[9:2], zero pad[15:10]
    output int          o_fail_count,
    output int          o_pending_words
);

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [MASK_W-1:0] fired_mask;
    } t_sched_word;

    t_sched_word       expected_words[$];
    int                mismatches = 0;
    int                pending_n  = 0;

    // shadow of the slot table
    logic              used_q      [NUM_SLOTS];
    logic              running_q   [NUM_SLOTS];
    logic [TIME_W-1:0] reload_q    [NUM_SLOTS];
    logic [TIME_W-1:0] remaining_q [NUM_SLOTS];

    assign o_fail_count    = mismatches;
    assign o_pending_words = pending_n;

    initial begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            used_q[s]      = 1'b0;
            running_q[s]   = 1'b0;
            reload_q[s]    = '0;
            remaining_q[s] = '0;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    endtask

    task automatic predict_sched_word(input logic [CMD_W-1:0] cmd,
                                      input logic [IDX_W-1:0] idx,
                                      input logic [TIME_W-1:0] per,
                                      input logic [TIME_W-1:0] dly,
                                      output t_sched_word res);
        res = '0;
        if (cmd == CMD_TICK) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                if (used_q[s] && running_q[s]) begin
                    if (remaining_q[s] == '0) begin
                        remaining_q[s] = reload_q[s];
                        if (s < MASK_W)
                            res.fired_mask[s] = 1'b1;
                    end else begin
                        remaining_q[s] = remaining_q[s] - TIME_W'(1);
                    end
                end
            end
        end else if (cmd >= CMD_CREATE && cmd <= CMD_DELETE) begin
            if (idx >= NUM_SLOTS) begin
                res.status = ST_RANGE;
            end else if (cmd == CMD_CREATE) begin
                if (used_q[idx]) begin
                    res.status = ST_USED;
                end else begin
                    used_q[idx]      = 1'b1;
                    running_q[idx]   = 1'b1;
                    reload_q[idx]    = per;
                    remaining_q[idx] = dly;
                end
            end else if (!used_q[idx]) begin
                res.status = ST_EMPTY;
            end else if (cmd == CMD_SUSPEND) begin
                running_q[idx] = 1'b0;
            end else if (cmd == CMD_RESUME) begin
                running_q[idx] = 1'b1;
            end else begin
                used_q[idx]    = 1'b0;
                running_q[idx] = 1'b0;
            end
        end
        // unknown commands leave status and mask at zero
    endtask

    always @(posedge i_clk) begin
        t_sched_word got;
        t_sched_word want;
        if (i_rst_n) begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.status     = i_m_axis_tdata[1:0];
                got.fired_mask = i_m_axis_tdata[9:2];
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected result word", 32'd0, 32'(got));
                end else begin
                    want = expected_words.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(got.status));
                    if (got.fired_mask !== want.fired_mask)
                        report_mismatch("fired_mask", 32'(want.fired_mask),
                                        32'(got.fired_mask));
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                predict_sched_word(i_s_axis_tuser, i_s_axis_tdata[7:0],
                                   i_s_axis_tdata[39:8], i_s_axis_tdata[71:40], want);
                expected_words.push_back(want);
            end
            pending_n = expected_words.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import ptts_pkg::*;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [71:0] i_s_axis_tdata  = '0;   // task_index[7:0], period[39:8], first_delay[71:40]
    logic [2:0]  i_s_axis_tuser  = '0;   // command[2:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;         // status[1:0], fired_mask[9:2], zero pad[15:10]

    int fail_count;
    int pending_words;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int idle_plan  [4] = '{0, 57, 0, 32};
    int stall_plan [4] = '{0, 0, 57, 32};

    periodic_task_tick_scheduler dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    tick_sched_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending_words (pending_words)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // result side back-pressure
    initial begin
        forever begin
            @(negedge i_clk);
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                             input logic [TIME_W-1:0] per, input logic [TIME_W-1:0] dly);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {dly, per, idx};
        i_s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic send_random_word();
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] per;
        logic [TIME_W-1:0] dly;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 40)      cmd = CMD_TICK;
        else if (pick < 65) cmd = CMD_CREATE;
        else if (pick < 75) cmd = CMD_SUSPEND;
        else if (pick < 85) cmd = CMD_RESUME;
        else if (pick < 96) cmd = CMD_DELETE;
        else                cmd = CMD_W'($urandom_range(7, 5));
        idx = ($urandom_range(99) < 90) ? IDX_W'($urandom_range(NUM_SLOTS - 1, 0))
                                        : IDX_W'($urandom_range(255, NUM_SLOTS));
        // mostly short periods so slots fire often; now and then any value
        per = ($urandom_range(99) < 6) ? $urandom : $urandom_range(12, 0);
        dly = ($urandom_range(99) < 6) ? $urandom : $urandom_range(12, 0);
        send_word(cmd, idx, per, dly);
    endtask

    // park the input and hold off until every result word is back
    task automatic drain_results();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        wait (pending_words == 0);
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        send_word(CMD_TICK,    8'hFF, '1, '1);
        send_word(CMD_CREATE,  8'd0,  '0, '0);
        send_word(CMD_CREATE,  8'd7,  '1, '1);
        send_word(CMD_CREATE,  8'd0,  32'd5, 32'd5);
        send_word(CMD_CREATE,  8'd8,  32'd1, 32'd1);
        send_word(CMD_CREATE,  8'hFF, 32'd1, 32'd1);
        send_word(CMD_SUSPEND, 8'd9,  '0, '0);
        send_word(CMD_RESUME,  8'd200, '0, '0);
        send_word(CMD_DELETE,  8'hFF, '0, '0);
        send_word(CMD_SUSPEND, 8'd3,  '0, '0);
        send_word(CMD_RESUME,  8'd3,  '0, '0);
        send_word(CMD_DELETE,  8'd3,  '0, '0);
        send_word(CMD_CREATE,  8'd3,  32'd2, 32'd1);
        send_word(CMD_TICK,    8'd0,  '0, '0);
        send_word(CMD_TICK,    8'd0,  '0, '0);
        send_word(CMD_SUSPEND, 8'd3,  '0, '0);
        send_word(CMD_SUSPEND, 8'd3,  '0, '0);
        send_word(CMD_TICK,    8'd0,  '0, '0);
        send_word(CMD_RESUME,  8'd3,  '0, '0);
        send_word(CMD_RESUME,  8'd3,  '0, '0);
        send_word(CMD_TICK,    8'd0,  '0, '0);
        send_word(3'd5,        8'd1,  '1, '0);
        send_word(3'd6,        8'd2,  '0, '1);
        send_word(3'd7,        8'hFF, '1, '1);
        send_word(CMD_DELETE,  8'd0,  '0, '0);
        send_word(CMD_TICK,    8'd0,  '0, '0);
        send_word(CMD_DELETE,  8'd7,  '0, '0);
        send_word(CMD_DELETE,  8'd3,  '0, '0);
        drain_results();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_plan[p];
            recv_stall_pct = stall_plan[p];
            repeat (150) send_random_word();
            drain_results();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
